>>> src/bsrt_pkg.sv
`default_nettype none
package bsrt_pkg;
   localparam int BUCKET_BITS  = 10;
   localparam int BUCKET_DEPTH = 16;
   localparam int REST_BITS    = 24 - BUCKET_BITS;
   localparam int NUM_BUCKETS  = 1 << BUCKET_BITS;
   localparam int POS_BITS     = $clog2(BUCKET_DEPTH);
   localparam int FILL_BITS    = $clog2(BUCKET_DEPTH + 1);
   localparam int SLOT_BITS    = BUCKET_BITS + POS_BITS;
   localparam int NUM_SLOTS    = NUM_BUCKETS * BUCKET_DEPTH;
   localparam int REC_BITS     = REST_BITS + 64 + 8 + 64 + 64 + 56;

   typedef enum logic [1:0] {
      FUNC_FIND = 2'd0, FUNC_FIND_ADD = 2'd1, FUNC_ADD = 2'd2, FUNC_RSVD = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_FOUND = 2'd0, ST_NOT_FOUND = 2'd1, ST_ADDED = 2'd2, ST_FULL = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FILL_RD, S_FILL_WAIT, S_SEARCH, S_RD_WAIT, S_CMP,
      S_DECIDE, S_SHIFT_RD, S_SHIFT_WAIT, S_SHIFT_WR, S_INSERT, S_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic clr_step;
      logic fill_load;
      logic search_init;
      logic mid_rd;
      logic cmp_step;
      logic hit_load;
      logic shift_init;
      logic shift_rd;
      logic shift_wr;
      logic ins_wr;
      logic set_result;
      status_type status;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic clr_done;
      logic search_done;
      logic hit;
      logic full;
      logic shift_done;
      func_type func;
   } stat_type;
endpackage
`default_nettype wire

>>> src/bsrt_if.sv
`default_nettype none
interface bsrt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [23:0] key_prefix;
   logic [63:0] key_high;
   logic [7:0]  key_low;
   logic [63:0] payload_a;
   logic [63:0] payload_b;
   logic [55:0] payload_c;
   modport source (output valid, func, key_prefix, key_high, key_low,
                   payload_a, payload_b, payload_c, input ready);
   modport sink (input valid, func, key_prefix, key_high, key_low,
                 payload_a, payload_b, payload_c, output ready);
endinterface

interface bsrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] found_payload_a;
   logic [63:0] found_payload_b;
   logic [55:0] found_payload_c;
   modport source (output valid, status, found_payload_a, found_payload_b,
                   found_payload_c, input ready);
   modport sink (input valid, status, found_payload_a, found_payload_b,
                 found_payload_c, output ready);
endinterface
`default_nettype wire

>>> src/bsrt_ram.sv
`default_nettype none
module bsrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> src/bsrt_ctrl.sv
`default_nettype none
module bsrt_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire bsrt_pkg::stat_type stat,
   output bsrt_pkg::ctrl_type      ctrl
);
   import bsrt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      ctrl.status = ST_FOUND;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ctrl.clr_step = 1'b1;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load_req = 1'b1;
               state_in = S_FILL_RD;
            end
         end
         S_FILL_RD: begin
            state_in = S_FILL_WAIT;
         end
         S_FILL_WAIT: begin
            ctrl.fill_load = 1'b1;
            ctrl.search_init = 1'b1;
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (stat.search_done) begin
               state_in = S_RD_WAIT;
            end else begin
               ctrl.mid_rd = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            // hold the mid address so its data is still there next cycle
            ctrl.mid_rd = 1'b1;
            state_in = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            // read data of mid or pos slot is valid here
            if (stat.search_done) begin
               ctrl.hit_load = 1'b1;
               state_in = S_DECIDE;
            end else begin
               ctrl.cmp_step = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_DECIDE: begin
            ctrl.set_result = 1'b1;
            if (stat.func != FUNC_ADD && stat.hit) begin
               ctrl.status = ST_FOUND;
               state_in = S_OUT;
            end else if (stat.func == FUNC_FIND || stat.func == FUNC_RSVD) begin
               ctrl.status = ST_NOT_FOUND;
               state_in = S_OUT;
            end else if (stat.full) begin
               ctrl.status = ST_FULL;
               state_in = S_OUT;
            end else begin
               ctrl.status = ST_ADDED;
               ctrl.shift_init = 1'b1;
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            if (stat.shift_done) begin
               state_in = S_INSERT;
            end else begin
               ctrl.shift_rd = 1'b1;
               state_in = S_SHIFT_WAIT;
            end
         end
         S_SHIFT_WAIT: begin
            // keep the source address for the write cycle
            ctrl.shift_rd = 1'b1;
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            ctrl.shift_wr = 1'b1;
            state_in = S_SHIFT_RD;
         end
         S_INSERT: begin
            ctrl.ins_wr = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end
endmodule
`default_nettype wire

>>> src/bsrt_dp.sv
`default_nettype none
module bsrt_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bsrt_pkg::ctrl_type  ctrl,
   output bsrt_pkg::stat_type       stat,
   input  wire logic [1:0]          req_func,
   input  wire logic [23:0]         req_key_prefix,
   input  wire logic [63:0]         req_key_high,
   input  wire logic [7:0]          req_key_low,
   input  wire logic [63:0]         req_payload_a,
   input  wire logic [63:0]         req_payload_b,
   input  wire logic [55:0]         req_payload_c,
   output logic [1:0]               rsp_status,
   output logic [63:0]              rsp_found_payload_a,
   output logic [63:0]              rsp_found_payload_b,
   output logic [55:0]              rsp_found_payload_c
);
   import bsrt_pkg::*;

   logic [1:0]            func_ff;
   logic [23:0]           prefix_ff;
   logic [63:0]           kh_ff, pa_ff, pb_ff;
   logic [7:0]            kl_ff;
   logic [55:0]           pc_ff;
   logic [FILL_BITS-1:0]  fill_ff, first_ff, count_ff, shift_ff;
   logic                  hit_ff;
   logic [BUCKET_BITS:0]  clr_ff;
   logic [1:0]            st_ff;
   logic [63:0]           ra_ff, rb_ff;
   logic [55:0]           rc_ff;

   logic [BUCKET_BITS-1:0] bucket;
   logic [REST_BITS-1:0]   rest;
   logic [FILL_BITS-1:0]   half, mid;

   // fill memory
   logic                   fill_we;
   logic [BUCKET_BITS-1:0] fill_wa;
   logic [FILL_BITS-1:0]   fill_wd, fill_rd;

   // record memory
   logic                   rec_we;
   logic [SLOT_BITS-1:0]   rec_wa, rec_ra;
   logic [REC_BITS-1:0]    rec_wd, rec_rd, probe;
   logic [REST_BITS+71:0]  rd_key, probe_key;

   assign bucket = prefix_ff[23 -: BUCKET_BITS];
   assign rest   = prefix_ff[REST_BITS-1:0];
   assign half   = count_ff >> 1;
   assign mid    = first_ff + half;
   assign probe  = {rest, kh_ff, kl_ff, pa_ff, pb_ff, pc_ff};
   assign rd_key    = rec_rd[REC_BITS-1 -: REST_BITS+72];
   assign probe_key = probe[REC_BITS-1 -: REST_BITS+72];

   bsrt_ram #(.WIDTH(FILL_BITS), .DEPTH(NUM_BUCKETS)) u_fill (
      .clock(clock), .wr_en(fill_we), .wr_addr(fill_wa), .wr_data(fill_wd),
      .rd_addr(bucket), .rd_data(fill_rd));

   bsrt_ram #(.WIDTH(REC_BITS), .DEPTH(NUM_SLOTS)) u_rec (
      .clock(clock), .wr_en(rec_we), .wr_addr(rec_wa), .wr_data(rec_wd),
      .rd_addr(rec_ra), .rd_data(rec_rd));

   // fill memory write: clearing pass or count update
   always_comb begin
      fill_we = ctrl.clr_step || ctrl.ins_wr;
      fill_wa = ctrl.clr_step ? clr_ff[BUCKET_BITS-1:0] : bucket;
      fill_wd = ctrl.clr_step ? '0 : fill_ff + 1'b1;
   end

   // record read address: mid during search, pos after, shift source
   always_comb begin
      if (ctrl.shift_rd) begin
         rec_ra = {bucket, POS_BITS'(shift_ff - 1'b1)};
      end else if (ctrl.mid_rd) begin
         rec_ra = {bucket, mid[POS_BITS-1:0]};
      end else begin
         rec_ra = {bucket, first_ff[POS_BITS-1:0]};
      end
   end

   // record write: shift up one slot or insert new record
   always_comb begin
      rec_we = ctrl.shift_wr || ctrl.ins_wr;
      if (ctrl.shift_wr) begin
         rec_wa = {bucket, shift_ff[POS_BITS-1:0]};
         rec_wd = rec_rd;
      end else begin
         rec_wa = {bucket, first_ff[POS_BITS-1:0]};
         rec_wd = probe;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctrl.clr_step && !clr_ff[BUCKET_BITS]) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // request, search and result registers
   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         func_ff   <= req_func;
         prefix_ff <= req_key_prefix;
         kh_ff     <= req_key_high;
         kl_ff     <= req_key_low;
         pa_ff     <= req_payload_a;
         pb_ff     <= req_payload_b;
         pc_ff     <= req_payload_c;
      end
      if (ctrl.fill_load) begin
         fill_ff <= (fill_rd > FILL_BITS'(BUCKET_DEPTH)) ? FILL_BITS'(BUCKET_DEPTH)
                                                        : fill_rd;
      end
      if (ctrl.search_init) begin
         first_ff <= '0;
         count_ff <= (fill_rd > FILL_BITS'(BUCKET_DEPTH)) ? FILL_BITS'(BUCKET_DEPTH)
                                                         : fill_rd;
      end else if (ctrl.cmp_step) begin
         if (rd_key < probe_key) begin
            first_ff <= mid + 1'b1;
            count_ff <= count_ff - half - 1'b1;
         end else begin
            count_ff <= half;
         end
      end
      if (ctrl.hit_load) begin
         hit_ff <= (first_ff < fill_ff) && (rd_key == probe_key);
         ra_ff  <= rec_rd[183:120];
         rb_ff  <= rec_rd[119:56];
         rc_ff  <= rec_rd[55:0];
      end
      if (ctrl.shift_init) begin
         shift_ff <= fill_ff;
      end else if (ctrl.shift_wr) begin
         shift_ff <= shift_ff - 1'b1;
      end
      if (ctrl.set_result) begin
         st_ff <= ctrl.status;
         if (ctrl.status != ST_FOUND) begin
            ra_ff <= '0;
            rb_ff <= '0;
            rc_ff <= '0;
         end
      end
   end

   always_comb begin
      stat.clr_done    = clr_ff[BUCKET_BITS];
      stat.search_done = (count_ff == '0);
      stat.hit         = hit_ff;
      stat.full        = (fill_ff >= FILL_BITS'(BUCKET_DEPTH));
      stat.shift_done  = (shift_ff == first_ff);
      stat.func        = func_type'(func_ff);
   end

   assign rsp_status          = st_ff;
   assign rsp_found_payload_a = ra_ff;
   assign rsp_found_payload_b = rb_ff;
   assign rsp_found_payload_c = rc_ff;
endmodule
`default_nettype wire

>>> src/bucketed_sorted_record_table_core.sv
`default_nettype none
// channel | dir | payload
// req     | in  | func, key_prefix, key_high, key_low, payload_a..c
// rsp     | out | status, found_payload_a..c
// a lookup reads the bucket fill count, then the mid record of each search
// step; an insert then shifts each record above the slot up one, through
// the record memory's single read port, up to fifteen records at 16 slots
// after reset the bucket fill memory is cleared, one bucket a cycle,
// before the first word is taken
// one item at a time; the result holds until rsp is taken, which stalls req
module bucketed_sorted_record_table_core (
   input wire logic  clock,
   input wire logic  reset,
   bsrt_req_if.sink  req,
   bsrt_rsp_if.source rsp
);
   import bsrt_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   bsrt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .stat(stat), .ctrl(ctrl));

   bsrt_dp u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_func(req.func), .req_key_prefix(req.key_prefix),
      .req_key_high(req.key_high), .req_key_low(req.key_low),
      .req_payload_a(req.payload_a), .req_payload_b(req.payload_b),
      .req_payload_c(req.payload_c), .rsp_status(rsp.status),
      .rsp_found_payload_a(rsp.found_payload_a),
      .rsp_found_payload_b(rsp.found_payload_b),
      .rsp_found_payload_c(rsp.found_payload_c));
endmodule
`default_nettype wire
